// File: rtl/plr_pkg.sv
`timescale 1ns / 1ps

package plr_pkg;

    localparam int LOG_FRAC = 28;
    localparam int D2_W     = 50;
    localparam int EXP_W    = 6;
    localparam int MANT_W   = 32;
    localparam int LOG_W    = EXP_W + LOG_FRAC;

    localparam logic [30:0] K_Q30   = 31'd1616142483;
    localparam logic [19:0] RES_MAX = 20'hFFFFF;

    typedef struct packed {
        logic signed [23:0] node_x;
        logic signed [23:0] node_y;
    } plr_in_t;

    typedef struct packed {
        logic [19:0] residual;
        logic        distance_zero;
        logic        saturated;
    } plr_out_t;

    typedef struct packed {
        logic valid;
        logic zero;
    } plr_tag_t;

    typedef enum logic [2:0] {
        REG_OBSERVED,
        REG_REFERENCE,
        REG_EXPONENT,
        REG_REF_DIST,
        REG_ANCHOR_X,
        REG_ANCHOR_Y
    } plr_reg_t;

    typedef enum logic [2:0] {
        LD_IDLE,
        LD_SQUARE,
        LD_LEAD,
        LD_NORM,
        LD_ITER
    } plr_ld_state_t;

    // position of the leading one, zero for inputs of zero or one
    function automatic logic [EXP_W-1:0] lead_one(input logic [D2_W-1:0] x);
        logic [EXP_W-1:0] e;
        e = '0;
        for (int i = 1; i < D2_W; i++) begin
            if (x[i]) begin
                e = EXP_W'(i);
            end
        end
        return e;
    endfunction

    // q1.31 mantissa with the leading one at the top
    function automatic logic [MANT_W-1:0] normalize(input logic [D2_W-1:0] x,
                                                    input logic [EXP_W-1:0] e);
        logic [D2_W-1:0] w;
        w = x << (EXP_W'(D2_W - 1) - e);
        return w[D2_W-1 -: MANT_W];
    endfunction

    // one squaring step: {fraction bit, new mantissa}
    function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
        logic [2*MANT_W-1:0] p;
        p = m * m;
        if (p[2*MANT_W-1]) begin
            return {1'b1, p[2*MANT_W-1 -: MANT_W]};
        end
        return {1'b0, p[2*MANT_W-2 -: MANT_W]};
    endfunction

endpackage

// File: rtl/rssi_path_loss_residual.sv
`timescale 1ns / 1ps

// Path-loss residual: each beat on s_ is a candidate node position and gives
// one beat on m_ with |observed - predicted| power in Q12.8 dB, one beat per
// cycle unless m_ready is low or the d0 log2 unit is busy. The depth is set
// by the 28 mantissa squaring stages of the log2 of the squared distance,
// one multiplier each. A write to reference_distance, and reset, start a log2
// of d0^2 in a separate iterative unit; s_ready stays low until it finishes.

module rssi_path_loss_residual
    import plr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  plr_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output plr_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [15:0] obs_reg, ref_reg;
    logic [11:0]        exp_reg;
    logic [23:0]        d0_reg;
    logic signed [23:0] ax_reg, ay_reg;

    logic               wr_en, d0_start, ld_busy, adv;
    logic [LOG_W-1:0]   l_den;

    // configuration
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obs_reg <= '0;
            ref_reg <= -16'sd10240;
            exp_reg <= 12'd512;
            d0_reg  <= 24'd256;
            ax_reg  <= '0;
            ay_reg  <= '0;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_OBSERVED:  obs_reg <= pwdata[15:0];
                REG_REFERENCE: ref_reg <= pwdata[15:0];
                REG_EXPONENT:  exp_reg <= pwdata[11:0];
                REG_REF_DIST:  d0_reg  <= pwdata[23:0];
                REG_ANCHOR_X:  ax_reg  <= pwdata[23:0];
                REG_ANCHOR_Y:  ay_reg  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_OBSERVED:  prdata = {16'd0, obs_reg};
            REG_REFERENCE: prdata = {16'd0, ref_reg};
            REG_EXPONENT:  prdata = {20'd0, exp_reg};
            REG_REF_DIST:  prdata = {8'd0, d0_reg};
            REG_ANCHOR_X:  prdata = {8'd0, ax_reg};
            REG_ANCHOR_Y:  prdata = {8'd0, ay_reg};
            default:       prdata = '0;
        endcase
    end

    assign d0_start = wr_en && (paddr[4:2] == REG_REF_DIST);

    plr_log2_iter u_log_den (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (d0_start),
        .d0      (d0_reg),
        .busy    (ld_busy),
        .log_out (l_den)
    );

    // pipeline
    logic               out_valid_reg;
    plr_out_t           out_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv && !ld_busy;

    logic signed [24:0] dx, dy;
    logic [24:0]        adx1_reg, ady1_reg;
    logic [48:0]        sqx2_reg, sqy2_reg;
    logic [D2_W-1:0]    d2_3_reg;
    logic               v1_reg, v2_reg, v3_reg;
    plr_tag_t           tag3, tag_l;
    logic [LOG_W-1:0]   l_num;

    assign dx = {ax_reg[23], ax_reg} - {s_data.node_x[23], s_data.node_x};
    assign dy = {ay_reg[23], ay_reg} - {s_data.node_y[23], s_data.node_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid && s_ready;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            adx1_reg <= dx[24] ? 25'(-dx) : 25'(dx);
            ady1_reg <= dy[24] ? 25'(-dy) : 25'(dy);
            sqx2_reg <= 49'(adx1_reg * adx1_reg);
            sqy2_reg <= 49'(ady1_reg * ady1_reg);
            d2_3_reg <= {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        end
    end

    assign tag3.valid = v3_reg;
    assign tag3.zero  = (d2_3_reg == '0);

    plr_log2_pipe u_log_num (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_tag   (tag3),
        .in_value (d2_3_reg),
        .out_tag  (tag_l),
        .out_log  (l_num)
    );

    plr_tag_t           t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic               pos1_reg, pos2_reg, pos3_reg;
    logic [LOG_W-1:0]   ldiff1_reg;
    logic [25:0]        t8_2_reg;
    logic [56:0]        term3_reg;
    logic signed [59:0] acc4_reg;
    logic [58:0]        mag5_reg;
    logic [45:0]        prod_t8;
    logic signed [16:0] esub;
    logic signed [59:0] e_sh, term_s;
    logic [59:0]        rnd;
    logic [21:0]        res;

    assign prod_t8 = ldiff1_reg * exp_reg;
    assign esub    = {obs_reg[15], obs_reg} - {ref_reg[15], ref_reg};
    assign e_sh    = 60'(esub) <<< 38;
    assign term_s  = $signed({3'b000, term3_reg});
    assign rnd     = {1'b0, mag5_reg} + (60'd1 << 37);
    assign res     = rnd[59:38];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0;
            t2_reg <= '0;
            t3_reg <= '0;
            t4_reg <= '0;
            t5_reg <= '0;
        end else if (adv) begin
            t1_reg <= tag_l;
            t2_reg <= t1_reg;
            t3_reg <= t2_reg;
            t4_reg <= t3_reg;
            t5_reg <= t4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pos1_reg   <= (l_num >= l_den);
            ldiff1_reg <= (l_num >= l_den) ? l_num - l_den : l_den - l_num;
            pos2_reg   <= pos1_reg;
            t8_2_reg   <= prod_t8[45:20];
            pos3_reg   <= pos2_reg;
            term3_reg  <= t8_2_reg * K_Q30;
            acc4_reg   <= pos3_reg ? e_sh + term_s : e_sh - term_s;
            mag5_reg   <= acc4_reg[59] ? 59'(-acc4_reg) : 59'(acc4_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= t5_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (t5_reg.zero) begin
                out_reg.residual      <= RES_MAX;
                out_reg.distance_zero <= 1'b1;
                out_reg.saturated     <= 1'b1;
            end else if (res[21:20] != 2'b00) begin
                out_reg.residual      <= RES_MAX;
                out_reg.distance_zero <= 1'b0;
                out_reg.saturated     <= 1'b1;
            end else begin
                out_reg.residual      <= res[19:0];
                out_reg.distance_zero <= 1'b0;
                out_reg.saturated     <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/plr_log2_pipe.sv
`timescale 1ns / 1ps

module plr_log2_pipe
    import plr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  plr_tag_t         in_tag,
    input  logic [D2_W-1:0]  in_value,
    output plr_tag_t         out_tag,
    output logic [LOG_W-1:0] out_log
);

    logic [D2_W-1:0]     x_reg;
    logic [EXP_W-1:0]    ea_reg;
    plr_tag_t            ta_reg;
    logic [MANT_W-1:0]   mb_reg;
    logic [EXP_W-1:0]    eb_reg;
    plr_tag_t            tb_reg;

    logic [MANT_W-1:0]   m_reg [LOG_FRAC];
    logic [LOG_FRAC-1:0] f_reg [LOG_FRAC];
    logic [EXP_W-1:0]    e_reg [LOG_FRAC];
    plr_tag_t            t_reg [LOG_FRAC];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ta_reg <= '0;
            tb_reg <= '0;
        end else if (en) begin
            ta_reg <= in_tag;
            tb_reg <= ta_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= in_value;
            ea_reg <= lead_one(in_value);
            mb_reg <= normalize(x_reg, ea_reg);
            eb_reg <= ea_reg;
        end
    end

    for (genvar k = 0; k < LOG_FRAC; k++) begin : g_step
        logic [MANT_W-1:0]   m_prev;
        logic [LOG_FRAC-1:0] f_prev;
        logic [EXP_W-1:0]    e_prev;
        plr_tag_t            t_prev;
        logic [MANT_W:0]     sq;
        logic [LOG_FRAC-1:0] f_next;

        if (k == 0) begin : g_first
            assign m_prev = mb_reg;
            assign f_prev = '0;
            assign e_prev = eb_reg;
            assign t_prev = tb_reg;
        end else begin : g_rest
            assign m_prev = m_reg[k-1];
            assign f_prev = f_reg[k-1];
            assign e_prev = e_reg[k-1];
            assign t_prev = t_reg[k-1];
        end

        assign sq     = sq_step(m_prev);
        assign f_next = f_prev | (LOG_FRAC'(sq[MANT_W]) << (LOG_FRAC - 1 - k));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                t_reg[k] <= '0;
            end else if (en) begin
                t_reg[k] <= t_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[k] <= sq[MANT_W-1:0];
                f_reg[k] <= f_next;
                e_reg[k] <= e_prev;
            end
        end
    end

    assign out_tag = t_reg[LOG_FRAC-1];
    assign out_log = {e_reg[LOG_FRAC-1], f_reg[LOG_FRAC-1]};

endmodule

// File: rtl/plr_log2_iter.sv
`timescale 1ns / 1ps

module plr_log2_iter
    import plr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [23:0]      d0,
    output logic             busy,
    output logic [LOG_W-1:0] log_out
);

    plr_ld_state_t       state_reg, state_next;
    logic [47:0]         x_reg;
    logic [EXP_W-1:0]    e_reg;
    logic [MANT_W-1:0]   m_reg;
    logic [LOG_FRAC-1:0] frac_reg;
    logic [4:0]          cnt_reg;
    logic [LOG_W-1:0]    log_reg;
    logic [23:0]         d0_eff;
    logic [MANT_W:0]     sq;
    logic                last;

    assign d0_eff = (d0 == '0) ? 24'd1 : d0;
    assign sq     = sq_step(m_reg);
    assign last   = (cnt_reg == 5'(LOG_FRAC - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LD_SQUARE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LD_IDLE:   state_next = LD_IDLE;
            LD_SQUARE: state_next = LD_LEAD;
            LD_LEAD:   state_next = LD_NORM;
            LD_NORM:   state_next = LD_ITER;
            LD_ITER:   state_next = last ? LD_IDLE : LD_ITER;
            default:   state_next = LD_IDLE;
        endcase
        if (start) begin
            state_next = LD_SQUARE;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            LD_SQUARE: x_reg <= d0_eff * d0_eff;
            LD_LEAD:   e_reg <= lead_one({2'b00, x_reg});
            LD_NORM: begin
                m_reg    <= normalize({2'b00, x_reg}, e_reg);
                frac_reg <= '0;
                cnt_reg  <= '0;
            end
            LD_ITER: begin
                m_reg    <= sq[MANT_W-1:0];
                frac_reg <= {frac_reg[LOG_FRAC-2:0], sq[MANT_W]};
                cnt_reg  <= cnt_reg + 5'd1;
                if (last) begin
                    log_reg <= {e_reg, frac_reg[LOG_FRAC-2:0], sq[MANT_W]};
                end
            end
            default: ;
        endcase
    end

    assign busy    = (state_reg != LD_IDLE);
    assign log_out = log_reg;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import plr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        plr_in_t  pos;
        bit       typed;
        plr_out_t res;
    } stim_row_t;

    typedef struct {
        bit       typed;
        plr_out_t res;
    } typed_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    plr_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    plr_out_t    m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic signed [15:0] cfg_observed  = 16'sd0;
    logic signed [15:0] cfg_reference = -16'sd10240;
    logic        [11:0] cfg_exponent  = 12'd512;
    logic        [23:0] cfg_ref_dist  = 24'd256;
    logic signed [23:0] cfg_anchor_x  = '0;
    logic signed [23:0] cfg_anchor_y  = '0;

    plr_out_t residual_q[$];
    typed_t   typed_q[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       quiet = 1'b0;
    bit       hold_req = 1'b0;

    rssi_path_loss_residual uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [63:0] log2_q28(logic [63:0] x);
        int          e;
        logic [63:0] m;
        logic [63:0] f;
        e = 0;
        f = '0;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        if (e >= 31) m = x >> (e - 31);
        else m = x << (31 - e);
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                f[LOG_FRAC - 1 - i] = 1'b1;
            end
        end
        return (64'(e) << LOG_FRAC) | f;
    endfunction

    function automatic plr_out_t predict_residual(plr_in_t p);
        longint      dx, dy, acc;
        logic [63:0] adx, ady, d2, d0v, l_num, l_den, ldiff, t8, term, mag, res;
        bit          pos;
        plr_out_t    r;
        dx = longint'(cfg_anchor_x) - longint'(p.node_x);
        dy = longint'(cfg_anchor_y) - longint'(p.node_y);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        d2 = adx * adx + ady * ady;
        r = '0;
        if (d2 == 0) begin
            r.residual = RES_MAX;
            r.distance_zero = 1'b1;
            r.saturated = 1'b1;
            return r;
        end
        d0v = (cfg_ref_dist != 0) ? 64'(cfg_ref_dist) : 64'd1;
        l_num = log2_q28(d2);
        l_den = log2_q28(d0v * d0v);
        pos = l_num >= l_den;
        ldiff = pos ? l_num - l_den : l_den - l_num;
        t8 = (ldiff * 64'(cfg_exponent)) >> (LOG_FRAC - 8);
        term = t8 * 64'(K_Q30);
        acc = (longint'(cfg_observed) - longint'(cfg_reference)) * 64'sd274877906944;
        if (pos) acc = acc + longint'(term);
        else acc = acc - longint'(term);
        mag = acc < 0 ? -acc : acc;
        res = (mag + (64'd1 << 37)) >> 38;
        if (res > 64'(RES_MAX)) begin
            r.residual = RES_MAX;
            r.saturated = 1'b1;
        end else begin
            r.residual = res[19:0];
        end
        return r;
    endfunction

    // input beats: expectation taken on the falling edge while valid and ready are both high
    always @(negedge aclk) begin
        typed_t t;
        if (aresetn && s_valid && s_ready) begin
            t = typed_q.pop_front();
            residual_q = {residual_q, (t.typed ? t.res : predict_residual(s_data))};
        end
    end

    always @(negedge aclk) begin
        plr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (residual_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", m_data);
            end else begin
                want = residual_q.pop_front();
                if (m_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected res=%0d zero=%b sat=%b, got res=%0d zero=%b sat=%b",
                                 want.residual, want.distance_zero, want.saturated,
                                 m_data.residual, m_data.distance_zero, m_data.saturated);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("** rssi_path_loss_residual: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (aresetn && !quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(plr_reg_t r, logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_OBSERVED:  cfg_observed = v[15:0];
            REG_REFERENCE: cfg_reference = v[15:0];
            REG_EXPONENT:  cfg_exponent = v[11:0];
            REG_REF_DIST:  cfg_ref_dist = v[23:0];
            REG_ANCHOR_X:  cfg_anchor_x = v[23:0];
            REG_ANCHOR_Y:  cfg_anchor_y = v[23:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (residual_q.size() != 0 || typed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic [15:0] obs, logic [15:0] refp, logic [11:0] n,
                              logic [23:0] d0, logic [23:0] ax, logic [23:0] ay);
        wait_idle();
        write_reg(REG_OBSERVED, 32'(obs));
        write_reg(REG_REFERENCE, 32'(refp));
        write_reg(REG_EXPONENT, 32'(n));
        write_reg(REG_REF_DIST, 32'(d0));
        write_reg(REG_ANCHOR_X, 32'(ax));
        write_reg(REG_ANCHOR_Y, 32'(ay));
    endtask

    // valid rises at a posedge and holds until a posedge with ready seen high
    task automatic send_pos(plr_in_t p, bit typed, plr_out_t res);
        typed_t t;
        t.typed = typed;
        t.res = res;
        typed_q = {typed_q, t};
        s_valid <= 1'b1;
        s_data <= p;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    function automatic plr_in_t random_pos();
        plr_in_t p;
        case ($urandom_range(0, 9))
            0: begin
                p.node_x = cfg_anchor_x;
                p.node_y = cfg_anchor_y;
            end
            1, 2, 3: begin
                p.node_x = cfg_anchor_x + 24'($signed($urandom_range(0, 2047)) - 1024);
                p.node_y = cfg_anchor_y + 24'($signed($urandom_range(0, 2047)) - 1024);
            end
            4: begin
                p.node_x = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                p.node_y = 24'($urandom);
            end
            default: begin
                p.node_x = 24'($urandom);
                p.node_y = 24'($urandom);
            end
        endcase
        return p;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) send_pos(random_pos(), 1'b0, '0);
    endtask

    initial begin
        stim_row_t rows[15];
        plr_in_t   p;
        plr_out_t  no_res;
        no_res = '0;
        rows[0]  = '{'{24'sd0, 24'sd0}, 1'b1, '{RES_MAX, 1'b1, 1'b1}};
        rows[1]  = '{'{24'sd256, 24'sd0}, 1'b1, '{20'd10240, 1'b0, 1'b0}};
        rows[2]  = '{'{24'sd0, -24'sd256}, 1'b1, '{20'd10240, 1'b0, 1'b0}};
        rows[3]  = '{'{24'h7FFFFF, 24'h7FFFFF}, 1'b0, no_res};
        rows[4]  = '{'{24'h800000, 24'h800000}, 1'b0, no_res};
        rows[5]  = '{'{24'h7FFFFF, 24'h800000}, 1'b0, no_res};
        rows[6]  = '{'{24'h800000, 24'sd0}, 1'b0, no_res};
        rows[7]  = '{'{24'sd0, 24'h7FFFFF}, 1'b0, no_res};
        rows[8]  = '{'{24'sd1, 24'sd0}, 1'b0, no_res};
        rows[9]  = '{'{24'sd0, -24'sd1}, 1'b0, no_res};
        rows[10] = '{'{-24'sd1, -24'sd1}, 1'b0, no_res};
        rows[11] = '{'{24'sd256, 24'sd256}, 1'b0, no_res};
        rows[12] = '{'{24'sd12800, -24'sd5120}, 1'b0, no_res};
        rows[13] = '{'{24'h555555, 24'hAAAAAA}, 1'b0, no_res};
        rows[14] = '{'{24'sd0, 24'sd0}, 1'b1, '{RES_MAX, 1'b1, 1'b1}};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (rows[i]) send_pos(rows[i].pos, rows[i].typed, rows[i].res);

        set_config(16'h7FFF, 16'h8000, 12'hFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF);
        for (int i = 0; i < 6; i++) begin
            p.node_x = (i & 1) ? 24'h7FFFFF : 24'h800000;
            p.node_y = (i & 2) ? 24'h7FFFFF : 24'h800000;
            send_pos(p, 1'b0, '0);
        end
        hold_req = 1'b1;
        random_phase(100);

        set_config(16'h8000, 16'h7FFF, 12'd0, 24'd1, 24'h7FFFFF, 24'h800000);
        random_phase(100);

        set_config(16'($urandom), 16'($urandom), 12'($urandom), 24'($urandom_range(1, 24'hFFFFFF)),
                   24'($urandom), 24'($urandom));
        random_phase(100);

        set_config(16'($urandom), 16'($urandom), 12'hFFF, 24'd1, 24'sd0, 24'sd0);
        random_phase(100);

        set_config(16'($urandom), 16'($urandom), 12'($urandom), 24'($urandom_range(1, 65535)),
                   24'($urandom), 24'($urandom));
        quiet = 1'b1;
        random_phase(100);

        wait_idle();
        if (mismatches == 0) begin
            $display("** rssi_path_loss_residual: PASSED **");
        end else begin
            $display("** rssi_path_loss_residual: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/plr_pkg.sv
rtl/plr_log2_pipe.sv
rtl/plr_log2_iter.sv
rtl/rssi_path_loss_residual.sv
tb/sv/tb_top.sv
